// ----- design/line_intersect_3d_unit_assert.svh -----
// Assertion macros for the line intersection unit checker
`ifndef LINE_INTERSECT_3D_UNIT_ASSERT_SVH
`define LINE_INTERSECT_3D_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define LID_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define LID_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// what must hold in the cycle after a reset edge
`define LID_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) else $error(msg);

`endif

// ----- design/lid_pkg.sv -----
`timescale 1ns / 1ps
package lid_pkg;

    localparam int QBits = 31;
    localparam int DenW  = 64;
    localparam int NumW  = 82;
    localparam int MagW  = 81;
    localparam int ThrW  = 40;
    localparam logic [ThrW-1:0] ThrReset = 40'd1390849702;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [15:0] dir_t;

    typedef struct packed {
        coord_t a_point_x;
        coord_t a_point_y;
        coord_t a_point_z;
        dir_t   a_dir_x;
        dir_t   a_dir_y;
        dir_t   a_dir_z;
        coord_t b_point_x;
        coord_t b_point_y;
        coord_t b_point_z;
        dir_t   b_dir_x;
        dir_t   b_dir_y;
        dir_t   b_dir_z;
    } lid_in_t;

    typedef struct packed {
        logic   found;
        coord_t hit_x;
        coord_t hit_y;
        coord_t hit_z;
    } lid_out_t;

    // beat moving through the divider cells
    typedef struct packed {
        logic [DenW-1:0]  rem;
        logic [QBits-1:0] dvd;
        logic [QBits-1:0] q;
        logic [DenW-1:0]  den;
        logic             neg;
        logic             ovf;
        logic             found;
        coord_t [2:0]     p2;
        dir_t   [2:0]     t2;
    } lid_div_t;

endpackage

// ----- design/lid_div_cell.sv -----
`timescale 1ns / 1ps
module lid_div_cell import lid_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  lid_div_t in_data,
    input  logic     in_valid,
    output logic     in_ready,
    output lid_div_t out_data,
    output logic     out_valid,
    input  logic     out_ready
);

    lid_div_t data_reg, data_next;
    logic     valid_reg;
    logic [DenW:0] rem2;
    logic [DenW:0] diff;

    assign in_ready  = !valid_reg || out_ready;
    assign out_data  = data_reg;
    assign out_valid = valid_reg;

    // one restoring step: quotient bit from shifted remainder
    always_comb begin
        data_next = in_data;
        rem2 = {in_data.rem, in_data.dvd[QBits-1]};
        diff = rem2 - {1'b0, in_data.den};
        data_next.dvd = {in_data.dvd[QBits-2:0], 1'b0};
        if (rem2 >= {1'b0, in_data.den}) begin
            data_next.rem = diff[DenW-1:0];
            data_next.q   = {in_data.q[QBits-2:0], 1'b1};
        end else begin
            data_next.rem = rem2[DenW-1:0];
            data_next.q   = {in_data.q[QBits-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- design/lid_front.sv -----
`timescale 1ns / 1ps
module lid_front import lid_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  lid_in_t         in_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [ThrW-1:0] thr,
    output lid_div_t        out_data,
    output logic            out_valid,
    input  logic            out_ready
);

    localparam int Stages = 7;
    localparam int Nx [3] = '{1, 2, 0};
    localparam int Ny [3] = '{2, 0, 1};

    logic [Stages-1:0] vld_reg;
    logic [Stages-1:0] adv;

    always_comb begin
        adv[Stages-1] = !vld_reg[Stages-1] || out_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[Stages-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= in_valid;
            for (int i = 1; i < Stages; i++) begin
                if (adv[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // unpacked input
    logic signed [31:0] p1 [3], p2 [3];
    logic signed [15:0] t1 [3], t2 [3];
    always_comb begin
        p1[0] = in_data.a_point_x; p1[1] = in_data.a_point_y; p1[2] = in_data.a_point_z;
        t1[0] = in_data.a_dir_x;   t1[1] = in_data.a_dir_y;   t1[2] = in_data.a_dir_z;
        p2[0] = in_data.b_point_x; p2[1] = in_data.b_point_y; p2[2] = in_data.b_point_z;
        t2[0] = in_data.b_dir_x;   t2[1] = in_data.b_dir_y;   t2[2] = in_data.b_dir_z;
    end

    // stage 1: c = t1 x t2, p1 - p2
    logic signed [31:0] ma1 [3], mb1 [3];
    logic signed [32:0] c1_next [3], df1_next [3];
    logic signed [32:0] c1_reg [3], df_reg [3][2];
    logic signed [15:0] t1_reg [3];
    coord_t [2:0] p2_reg [Stages-1];
    dir_t   [2:0] t2_reg [Stages-1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ma1[k]      = t1[Nx[k]] * t2[Ny[k]];
            mb1[k]      = t1[Ny[k]] * t2[Nx[k]];
            c1_next[k]  = ma1[k] - mb1[k];
            df1_next[k] = p1[k] - p2[k];
        end
    end

    // stage 2: v = c x t1, squares of c
    logic signed [47:0] ma2 [3], mb2 [3];
    logic signed [47:0] v2_next [3], v2_reg [3];
    logic signed [65:0] sqf [3];
    logic [DenW-1:0] sq2_reg [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ma2[k]     = c1_reg[Nx[k]] * t1_reg[Ny[k]];
            mb2[k]     = c1_reg[Ny[k]] * t1_reg[Nx[k]];
            v2_next[k] = ma2[k] - mb2[k];
            sqf[k]     = c1_reg[k] * c1_reg[k];
        end
    end

    // stage 3: denominator, split partial products of v.(p1-p2)
    logic [DenW-1:0] d_reg [3:6];
    logic signed [57:0] pl3_reg [3];
    logic signed [56:0] ph3_reg [3];

    // stage 4..6
    logic signed [NumW-1:0] hx4 [3];
    logic signed [NumW-1:0] n4_reg [3];
    logic signed [NumW-1:0] num5_reg;
    logic signed [NumW-1:0] neg_num;
    logic [MagW-1:0] mag6_reg;
    logic neg6_reg;
    logic [6:4] found_reg;
    lid_div_t div_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hx4[k] = NumW'(ph3_reg[k]);
        end
        neg_num = -num5_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int k = 0; k < 3; k++) begin
                c1_reg[k]    <= c1_next[k];
                df_reg[k][0] <= df1_next[k];
                t1_reg[k]    <= t1[k];
                p2_reg[0][k] <= p2[k];
                t2_reg[0][k] <= t2[k];
            end
        end
        if (adv[1]) begin
            for (int k = 0; k < 3; k++) begin
                v2_reg[k]    <= v2_next[k];
                sq2_reg[k]   <= sqf[k][DenW-1:0];
                df_reg[k][1] <= df_reg[k][0];
            end
        end
        if (adv[2]) begin
            d_reg[3] <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            for (int k = 0; k < 3; k++) begin
                pl3_reg[k] <= $signed({1'b0, v2_reg[k][23:0]}) * df_reg[k][1];
                ph3_reg[k] <= $signed(v2_reg[k][47:24]) * df_reg[k][1];
            end
        end
        if (adv[3]) begin
            for (int k = 0; k < 3; k++) begin
                n4_reg[k] <= (hx4[k] <<< 24) + NumW'(pl3_reg[k]);
            end
            d_reg[4]     <= d_reg[3];
            found_reg[4] <= (d_reg[3] != '0) && (d_reg[3] >= {10'b0, thr, 14'b0});
        end
        if (adv[4]) begin
            num5_reg     <= n4_reg[0] + n4_reg[1] + n4_reg[2];
            d_reg[5]     <= d_reg[4];
            found_reg[5] <= found_reg[4];
        end
        if (adv[5]) begin
            neg6_reg     <= num5_reg[NumW-1];
            mag6_reg     <= num5_reg[NumW-1] ? neg_num[MagW-1:0] : num5_reg[MagW-1:0];
            d_reg[6]     <= d_reg[5];
            found_reg[6] <= found_reg[5];
        end
        if (adv[6]) begin
            // quotient of 2^31 or more saturates
            div_reg.rem   <= mag6_reg[MagW-1:17];
            div_reg.ovf   <= mag6_reg[MagW-1:17] >= d_reg[6];
            div_reg.dvd   <= {mag6_reg[16:0], 14'b0};
            div_reg.q     <= '0;
            div_reg.den   <= d_reg[6];
            div_reg.neg   <= neg6_reg;
            div_reg.found <= found_reg[6];
            div_reg.p2    <= p2_reg[5];
            div_reg.t2    <= t2_reg[5];
        end
        for (int i = 1; i < Stages - 1; i++) begin
            if (adv[i]) begin
                p2_reg[i] <= p2_reg[i-1];
                t2_reg[i] <= t2_reg[i-1];
            end
        end
    end

    assign out_data = div_reg;

endmodule

// ----- design/lid_back.sv -----
`timescale 1ns / 1ps
module lid_back import lid_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  lid_div_t in_data,
    input  logic     in_valid,
    output logic     in_ready,
    output lid_out_t out_data,
    output logic     out_valid,
    input  logic     out_ready
);

    localparam int Stages = 3;

    logic [Stages-1:0] vld_reg;
    logic [Stages-1:0] adv;

    always_comb begin
        adv[Stages-1] = !vld_reg[Stages-1] || out_ready;
        for (int i = Stages - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[Stages-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= in_valid;
            for (int i = 1; i < Stages; i++) begin
                if (adv[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    logic signed [31:0] s_next, s_reg;
    logic signed [31:0] qs;
    logic signed [47:0] pr_reg [3];
    logic signed [47:0] sh [3], h [3];
    logic signed [31:0] hs [3];
    logic [2:1] found_reg;
    coord_t [2:0] p2_reg [2];
    dir_t   [2:0] t2_reg;
    lid_out_t out_reg;

    always_comb begin
        qs = $signed({1'b0, in_data.q});
        if (in_data.ovf) begin
            s_next = in_data.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            s_next = in_data.neg ? -qs : qs;
        end
        for (int k = 0; k < 3; k++) begin
            sh[k] = pr_reg[k] >>> 14;
            h[k]  = $signed(p2_reg[1][k]) + sh[k];
            if (h[k] > 48'sh0000_7fff_ffff) begin
                hs[k] = 32'sh7fff_ffff;
            end else if (h[k] < -48'sh0000_8000_0000) begin
                hs[k] = 32'sh8000_0000;
            end else begin
                hs[k] = h[k][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s_reg        <= s_next;
            found_reg[1] <= in_data.found;
            p2_reg[0]    <= in_data.p2;
            t2_reg       <= in_data.t2;
        end
        if (adv[1]) begin
            for (int k = 0; k < 3; k++) begin
                pr_reg[k] <= s_reg * $signed(t2_reg[k]);
            end
            found_reg[2] <= found_reg[1];
            p2_reg[1]    <= p2_reg[0];
        end
        if (adv[2]) begin
            out_reg.found <= found_reg[2];
            out_reg.hit_x <= found_reg[2] ? hs[0] : '0;
            out_reg.hit_y <= found_reg[2] ? hs[1] : '0;
            out_reg.hit_z <= found_reg[2] ? hs[2] : '0;
        end
    end

    assign out_data = out_reg;

endmodule

// ----- design/line_intersect_3d_unit.sv -----
`timescale 1ns / 1ps
// channel  | signals                  | payload
// ---------+--------------------------+----------------------------------
// input    | s_valid / s_ready        | s_data  (lid_in_t, two lines)
// result   | m_valid / m_ready        | m_data  (lid_out_t, found + hit)
// config   | psel penable pwrite ...  | parallel_threshold at address 0
//
// One beat per cycle in and out while m_ready is high; 7 front stages
// (cross products, dot products, magnitude), 31 divider cells, one per
// quotient bit, and 3 back stages (saturate s, s*t2, add and clamp).
// Every stage holds its beat when the next one is full, so bubbles close
// up and input keeps flowing while a result waits on m_ready, until all
// 41 stages hold a beat.
// Synchronous active-low reset empties the pipe and restores the threshold.
module line_intersect_3d_unit import lid_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  lid_in_t     s_data,
    input  logic        s_valid,
    output logic        s_ready,
    output lid_out_t    m_data,
    output logic        m_valid,
    input  logic        m_ready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic RegThr = 1'b0;

    logic [ThrW-1:0] thr_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == RegThr) ? {{(64-ThrW){1'b0}}, thr_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= ThrReset;
        end else if (psel && penable && pwrite && pready && paddr[3] == RegThr) begin
            thr_reg <= pwdata[ThrW-1:0];
        end
    end

    lid_div_t chain [QBits+1];
    logic     vchain [QBits+1];
    logic     rchain [QBits+1];

    lid_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_data),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .thr       (thr_reg),
        .out_data  (chain[0]),
        .out_valid (vchain[0]),
        .out_ready (rchain[0])
    );

    for (genvar i = 0; i < QBits; i++) begin : g_cell
        lid_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_data   (chain[i]),
            .in_valid  (vchain[i]),
            .in_ready  (rchain[i]),
            .out_data  (chain[i+1]),
            .out_valid (vchain[i+1]),
            .out_ready (rchain[i+1])
        );
    end

    lid_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (chain[QBits]),
        .in_valid  (vchain[QBits]),
        .in_ready  (rchain[QBits]),
        .out_data  (m_data),
        .out_valid (m_valid),
        .out_ready (m_ready)
    );

endmodule

// ----- design/lid_checker.sv -----
`timescale 1ns / 1ps
`include "line_intersect_3d_unit_assert.svh"
module lid_checker import lid_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input lid_out_t    m_data,
    input logic        m_valid,
    input logic        m_ready
);

    `LID_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")
    `LID_ASSERT_IMPL(a_zero, m_valid && !m_data.found, m_data.hit_x == 0 && m_data.hit_y == 0 && m_data.hit_z == 0, "parallel result carries a nonzero point")
    `LID_ASSERT_RST(a_rst, !m_valid && s_ready, "pipe not empty after reset")

endmodule

bind line_intersect_3d_unit lid_checker u_lid_checker (.*);
